@@ rtl/mv4_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mv4_pkg;

   localparam int FRAC_BITS_DEFAULT  = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed widths of the ports.
   localparam int FIELD_WIDTH     = 32;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 4;

   localparam int VEC_LEN       = 4;
   localparam int NUM_PAIRS     = 8;
   localparam int PAIR_IDX_BITS = 3;
   localparam int HALF_WIDTH    = 32;

   // Pipeline depth of one lane, from the multiply to the saturated result.
   localparam int LANE_STAGES = 5;

   // Identity matrix in column-major pairs.
   localparam logic [CSR_DATA_WIDTH-1:0] COEF_RESET [NUM_PAIRS] = '{
      64'd65536, 64'd0, 64'h0001_0000_0000_0000, 64'd0,
      64'd0, 64'd65536, 64'd0, 64'h0001_0000_0000_0000
   };

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] value;
      logic                          sat;
   } lane_result_type;

endpackage

`default_nettype wire

@@ rtl/matrix4_vector_transform.sv @@
`timescale 1ns / 1ps
`default_nettype none
// The result is on the rsp ports for one cycle, after the registers multiply, pair add,
// final add, round, saturate and output.
// Throughput: one item per cycle; busy stays low and the four row lanes are fully pipelined.
// Reset (synchronous, active high) restores the identity matrix and drops all items in flight.
// The receiver cannot stall; rsp_strobe marks each result for exactly one cycle.
module matrix4_vector_transform #(
   parameter int FRAC_BITS  = mv4_pkg::FRAC_BITS_DEFAULT,
   parameter int DATA_WIDTH = mv4_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic signed [mv4_pkg::FIELD_WIDTH-1:0]  req_in_x,
   input  wire logic signed [mv4_pkg::FIELD_WIDTH-1:0]  req_in_y,
   input  wire logic signed [mv4_pkg::FIELD_WIDTH-1:0]  req_in_z,
   input  wire logic signed [mv4_pkg::FIELD_WIDTH-1:0]  req_in_w,
   output logic                                         rsp_strobe,
   output logic signed [mv4_pkg::FIELD_WIDTH-1:0]       rsp_out_x,
   output logic signed [mv4_pkg::FIELD_WIDTH-1:0]       rsp_out_y,
   output logic signed [mv4_pkg::FIELD_WIDTH-1:0]       rsp_out_z,
   output logic signed [mv4_pkg::FIELD_WIDTH-1:0]       rsp_out_w,
   output logic                                         rsp_overflow,
   input  wire logic                                    csr_write_enable,
   input  wire logic [mv4_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [mv4_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data
);

   localparam int VecLen  = mv4_pkg::VEC_LEN;
   localparam int NPairs  = mv4_pkg::NUM_PAIRS;
   localparam int HalfW   = mv4_pkg::HALF_WIDTH;
   localparam int Stages  = mv4_pkg::LANE_STAGES;
   localparam int OutW    = mv4_pkg::FIELD_WIDTH;

   localparam logic signed [DATA_WIDTH-1:0] DataMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] DataMin = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [OutW-1:0] OutMax = OutW'(DataMax);
   localparam logic signed [OutW-1:0] OutMin = OutW'(DataMin);

   logic [mv4_pkg::CSR_DATA_WIDTH-1:0] coef_in [NPairs];
   logic [mv4_pkg::CSR_DATA_WIDTH-1:0] coef_ff [NPairs];
   logic [Stages-1:0] valid_in;
   logic [Stages-1:0] valid_ff;
   logic accept;

   logic signed [DATA_WIDTH-1:0] vec [VecLen];
   logic signed [DATA_WIDTH-1:0] lane_coef [VecLen][VecLen];
   mv4_pkg::lane_result_type lane_result [VecLen];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      coef_in = coef_ff;
      if (csr_write_enable && (int'(csr_index) < NPairs)) begin
         coef_in[csr_index[mv4_pkg::PAIR_IDX_BITS-1:0]] = csr_write_data;
      end
      valid_in = {valid_ff[Stages-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff  <= mv4_pkg::COEF_RESET;
         valid_ff <= '0;
      end else begin
         coef_ff  <= coef_in;
         valid_ff <= valid_in;
      end
   end

   assign vec[0] = req_in_x[DATA_WIDTH-1:0];
   assign vec[1] = req_in_y[DATA_WIDTH-1:0];
   assign vec[2] = req_in_z[DATA_WIDTH-1:0];
   assign vec[3] = req_in_w[DATA_WIDTH-1:0];

   // Element k = row + 4 * column lives in pair k / 2, low half for even k.
   for (genvar r = 0; r < VecLen; r++) begin : g_lane
      for (genvar c = 0; c < VecLen; c++) begin : g_coef
         localparam int K = r + VecLen * c;
         assign lane_coef[r][c] = coef_ff[K / 2][(K % 2) * HalfW +: DATA_WIDTH];
      end

      mv4_lane #(
         .FRAC_BITS  (FRAC_BITS),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_lane (
         .clock  (clock),
         .coef   (lane_coef[r]),
         .vec    (vec),
         .result (lane_result[r])
      );
   end

   mv4_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .lane_valid   (valid_ff[Stages-1]),
      .lane_result  (lane_result),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .rsp_out_w    (rsp_out_w),
      .rsp_overflow (rsp_overflow)
   );

   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, Stages + 1))
      else $error("result strobe without an item accepted earlier");

   a_item_reaches_output: assert property (@(posedge clock) disable iff (reset)
      valid_ff[Stages-1] |=> rsp_strobe)
      else $error("item in the last lane stage did not reach the output");

   a_overflow_at_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_overflow) |->
         (rsp_out_x == OutMax || rsp_out_x == OutMin ||
          rsp_out_y == OutMax || rsp_out_y == OutMin ||
          rsp_out_z == OutMax || rsp_out_z == OutMin ||
          rsp_out_w == OutMax || rsp_out_w == OutMin))
      else $error("overflow flagged but no component is at a bound");

endmodule

`default_nettype wire

@@ rtl/mv4_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mv4_lane #(
   parameter int FRAC_BITS  = mv4_pkg::FRAC_BITS_DEFAULT,
   parameter int DATA_WIDTH = mv4_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic signed [DATA_WIDTH-1:0] coef [mv4_pkg::VEC_LEN],
   input  wire logic signed [DATA_WIDTH-1:0] vec  [mv4_pkg::VEC_LEN],
   output mv4_pkg::lane_result_type          result
);

   localparam int ProdW   = 2 * DATA_WIDTH;
   localparam int PairW   = ProdW + 1;
   localparam int SumW    = ProdW + 2;
   localparam int OutW    = mv4_pkg::FIELD_WIDTH;
   localparam int VecLen  = mv4_pkg::VEC_LEN;
   localparam int NPair   = VecLen / 2;
   localparam int HalfPos = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;

   localparam logic signed [SumW-1:0] Half =
      (FRAC_BITS > 0) ? (SumW'(1) << HalfPos) : '0;
   localparam logic signed [DATA_WIDTH-1:0] MaxVal = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic signed [ProdW-1:0] prod_in [VecLen];
   logic signed [ProdW-1:0] prod_ff [VecLen];
   logic signed [PairW-1:0] pair_in [NPair];
   logic signed [PairW-1:0] pair_ff [NPair];
   logic signed [SumW-1:0]  sum_in;
   logic signed [SumW-1:0]  sum_ff;
   logic signed [SumW-1:0]  round_in;
   logic signed [SumW-1:0]  round_ff;
   logic [SumW-DATA_WIDTH:0] upper;
   logic signed [DATA_WIDTH-1:0] sat_value;
   mv4_pkg::lane_result_type result_in;
   mv4_pkg::lane_result_type result_ff;

   always_comb begin
      for (int i = 0; i < VecLen; i++) begin
         prod_in[i] = ProdW'(coef[i]) * ProdW'(vec[i]);
      end
      for (int j = 0; j < NPair; j++) begin
         pair_in[j] = PairW'(prod_ff[2*j]) + PairW'(prod_ff[2*j+1]);
      end
      sum_in   = SumW'(pair_ff[0]) + SumW'(pair_ff[1]);
      // Round to nearest with ties toward plus infinity: add one half, then floor.
      round_in = (sum_ff + Half) >>> FRAC_BITS;
   end

   // The rounded value fits when every bit from the target sign bit upward agrees.
   always_comb begin
      upper = round_ff[SumW-1:DATA_WIDTH-1];
      result_in.sat = !((&upper) || !(|upper));
      if (!result_in.sat) begin
         sat_value = round_ff[DATA_WIDTH-1:0];
      end else if (round_ff[SumW-1]) begin
         sat_value = MinVal;
      end else begin
         sat_value = MaxVal;
      end
      result_in.value = OutW'(sat_value);
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      pair_ff   <= pair_in;
      sum_ff    <= sum_in;
      round_ff  <= round_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

@@ rtl/mv4_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mv4_merge (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 lane_valid,
   input  wire mv4_pkg::lane_result_type             lane_result [mv4_pkg::VEC_LEN],
   output logic                                      rsp_strobe,
   output logic signed [mv4_pkg::FIELD_WIDTH-1:0]    rsp_out_x,
   output logic signed [mv4_pkg::FIELD_WIDTH-1:0]    rsp_out_y,
   output logic signed [mv4_pkg::FIELD_WIDTH-1:0]    rsp_out_z,
   output logic signed [mv4_pkg::FIELD_WIDTH-1:0]    rsp_out_w,
   output logic                                      rsp_overflow
);

   localparam int VecLen = mv4_pkg::VEC_LEN;

   logic strobe_in;
   logic strobe_ff;
   logic overflow_in;
   logic overflow_ff;
   logic signed [mv4_pkg::FIELD_WIDTH-1:0] value_in [VecLen];
   logic signed [mv4_pkg::FIELD_WIDTH-1:0] value_ff [VecLen];

   always_comb begin
      strobe_in   = lane_valid;
      overflow_in = 1'b0;
      for (int r = 0; r < VecLen; r++) begin
         value_in[r] = lane_result[r].value;
         overflow_in = overflow_in | lane_result[r].sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      overflow_ff <= overflow_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_out_x    = value_ff[0];
   assign rsp_out_y    = value_ff[1];
   assign rsp_out_z    = value_ff[2];
   assign rsp_out_w    = value_ff[3];
   assign rsp_overflow = overflow_ff;

endmodule

`default_nettype wire
